// File: rtl/core/igf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_pkg
// Shared types and constants of the inverse-square gravity field pipeline.
// ----------------------------------------------------------------------------
package igf_pkg;

  localparam int FRAC_BITS = 16;

  // Widths of the arithmetic chain
  localparam int DIST_W = 34;               // floor sqrt of a 66-bit sum
  localparam int QUO_W  = 52;               // quotient bits of every division
  localparam int DVD_W  = DIST_W + QUO_W;   // dividend bits seen by a divider
  localparam int RAD_W  = 68;               // radicand, two bits per root bit
  localparam int SREM_W = DIST_W + 2;       // square root partial remainder
  localparam int SQRT_N = RAD_W / 2;
  localparam int DIV_N  = QUO_W;

  // Register stages an item passes through, from st1 to the result register
  localparam int LAT = 3 + SQRT_N + 1 + DIV_N + 2 + DIV_N + 3 + DIV_N + 1;

  localparam logic [DIST_W-1:0] NEAR_RAW =
    DIST_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] RADIUS_RESET = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0] GRAV_RESET   =
    31'((64'd981 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_SURF_GRAV  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } query_t;

  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] grav_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               too_close;
    logic               clamped;
  } result_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [DIST_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_state_t;

  typedef struct packed {
    logic [DIST_W-1:0] rem;
    logic [QUO_W-1:0]  sh;    // dividend bits not yet used, quotient bits below
    logic [DIST_W-1:0] d;
  } div_state_t;

  // Per-item data riding alongside the arithmetic cells
  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic [2:0][31:0]  vel;
    logic [DIST_W-1:0] distance;
    logic              near;
    logic              active;
    logic              clamp;
  } item_t;

endpackage

// File: rtl/core/igf_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_sqrt_cell
// One registered step of a restoring square root: one root bit per cell.
// ----------------------------------------------------------------------------
module igf_sqrt_cell (
  input  logic                 clk,
  input  igf_pkg::sqrt_state_t cur,
  output igf_pkg::sqrt_state_t nxt
);
  import igf_pkg::*;

  logic [SREM_W+1:0] acc;
  logic [SREM_W+1:0] trial;
  logic              ge;

  always_comb begin
    acc   = {cur.rem, cur.rad[RAD_W-1 -: 2]};
    trial = {2'b00, cur.root, 2'b01};
    ge    = (acc >= trial);
  end

  always_ff @(posedge clk) begin
    nxt.rem  <= ge ? SREM_W'(acc - trial) : acc[SREM_W-1:0];
    nxt.root <= {cur.root[DIST_W-2:0], ge};
    nxt.rad  <= {cur.rad[RAD_W-3:0], 2'b00};
  end

endmodule

// File: rtl/core/igf_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_div_cell
// One registered step of a restoring divider: one quotient bit per cell.
// ----------------------------------------------------------------------------
module igf_div_cell (
  input  logic                clk,
  input  igf_pkg::div_state_t cur,
  output igf_pkg::div_state_t nxt
);
  import igf_pkg::*;

  logic [DIST_W:0] acc;
  logic            ge;

  always_comb begin
    acc = {cur.rem, cur.sh[QUO_W-1]};
    ge  = (acc >= {1'b0, cur.d});
  end

  always_ff @(posedge clk) begin
    nxt.rem <= ge ? DIST_W'(acc - {1'b0, cur.d}) : acc[DIST_W-1:0];
    nxt.sh  <= {cur.sh[QUO_W-2:0], ge};
    nxt.d   <= cur.d;
  end

endmodule

// File: rtl/core/igf_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_div_chain
// Row of divider cells; takes a new division every cycle.
// ----------------------------------------------------------------------------
module igf_div_chain (
  input  logic                        clk,
  input  logic [igf_pkg::DVD_W-1:0]   dividend,
  input  logic [igf_pkg::DIST_W-1:0]  divisor,
  output logic [igf_pkg::QUO_W-1:0]   quotient
);
  import igf_pkg::*;

  div_state_t st [0:DIV_N];

  // Quotient is known to fit QUO_W bits, so the top bits start as remainder
  assign st[0] = '{rem: dividend[DVD_W-1:QUO_W], sh: dividend[QUO_W-1:0], d: divisor};

  for (genvar k = 0; k < DIV_N; k++) begin : g_cell
    igf_div_cell u_cell (
      .clk (clk),
      .cur (st[k]),
      .nxt (st[k+1])
    );
  end

  assign quotient = st[DIV_N].sh;

endmodule

// File: rtl/core/inverse_square_gravity_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_square_gravity_field
// Gravity of one attractor at a query point, plus updated velocity.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a query item; it is taken on any edge where busy is low.
//   busy never rises, so one item enters every cycle.
//   Each item produces one result, shown on result for one cycle with done
//   high. Results leave in order.
//   The receiver has no way to stall; it must take every done cycle.
//   The distance comes from a row of 34 square root cells, then three rows of
//   52 divider cells (g*R/dist, then *R/dist, then |dir|*strength/dist for
//   each axis); the cell rows and multiplier stages set the latency.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no item is in flight.
//   Synchronous reset clears the in-flight valid bits and restores the
//   attractor registers (center 0, radius 1.0, surface gravity 9.81).
// ----------------------------------------------------------------------------
module inverse_square_gravity_field (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  igf_pkg::query_t  query,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             done,
  output igf_pkg::result_t result
);
  import igf_pkg::*;

  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0]        body_radius;
  logic [30:0]        surface_gravity;

  logic               accept;
  logic [LAT-2:0]     vld;

  // front end
  logic [2:0][32:0]   dir;
  item_t              st1, st2, st3;
  logic [2:0][63:0]   sq;
  logic [65:0]        sum;

  // square root row
  sqrt_state_t        sq_st [0:SQRT_N];
  item_t              sd_sq [0:SQRT_N-1];
  logic [DIST_W-1:0]  distance;

  // strength
  item_t              p1;
  item_t              p1_next;
  item_t              sd_a_next;
  logic [61:0]        p1_gr, p1_rr;
  logic [59:0]        p1_dd;
  logic [63:0]        clamp_lim;
  logic               clamp;
  logic [QUO_W-1:0]   quot_a, quot_b;
  item_t              sd_a [0:DIV_N-1];
  item_t              p2, p3, p4, p5, p6;
  logic [56:0]        pa_lo, pa_hi;
  logic [82:0]        tr_full;
  logic [63:0]        tr;
  item_t              sd_b [0:DIV_N-1];
  logic [QUO_W-1:0]   g_ten;
  logic [QUO_W-1:0]   strength;

  // per-axis products and division
  logic [2:0][57:0]   pb_lo, pb_hi;
  logic [2:0][83:0]   prod;
  logic [QUO_W-1:0]   quot_c [0:2];
  item_t              sd_c [0:DIV_N-1];
  logic [2:0][31:0]   grav;
  logic [2:0][31:0]   new_vel;

  assign accept    = start && !busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      center_z        <= '0;
      body_radius     <= RADIUS_RESET;
      surface_gravity <= GRAV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_CENTER_X:  center_x        <= cfg_data;
        REG_CENTER_Y:  center_y        <= cfg_data;
        REG_CENTER_Z:  center_z        <= cfg_data;
        REG_RADIUS:    body_radius     <= cfg_data[30:0];
        REG_SURF_GRAV: surface_gravity <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-3:0], accept};
      done <= vld[LAT-2];
    end
  end

  // dir = center - point, exact in 33 bits; magnitude fits 32 bits
  always_comb begin
    dir[0] = {center_x[31], center_x} - {query.point_x[31], query.point_x};
    dir[1] = {center_y[31], center_y} - {query.point_y[31], query.point_y};
    dir[2] = {center_z[31], center_z} - {query.point_z[31], query.point_z};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      st1.neg[i] <= dir[i][32];
      st1.mag[i] <= dir[i][32] ? 32'(-dir[i]) : dir[i][31:0];
    end
    st1.vel[0]    <= query.vel_x;
    st1.vel[1]    <= query.vel_y;
    st1.vel[2]    <= query.vel_z;
    st1.distance  <= '0;
    st1.near      <= 1'b0;
    st1.active    <= 1'b0;
    st1.clamp     <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= st1.mag[i] * st1.mag[i];
    end
    st2 <= st1;
    sum <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
    st3 <= st2;
  end

  assign sq_st[0] = '{rem: '0, root: '0, rad: {{(RAD_W-66){1'b0}}, sum}};

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    igf_sqrt_cell u_cell (
      .clk (clk),
      .cur (sq_st[k]),
      .nxt (sq_st[k+1])
    );
  end

  assign distance = sq_st[SQRT_N].root;

  always_ff @(posedge clk) begin
    sd_sq[0] <= st3;
    for (int k = 1; k < SQRT_N; k++) begin
      sd_sq[k] <= sd_sq[k-1];
    end
  end

  // P1: distance known
  always_comb begin
    p1_next          = sd_sq[SQRT_N-1];
    p1_next.distance = distance;
    p1_next.near     = (distance < NEAR_RAW);
    p1_next.active   = (distance >= NEAR_RAW) && (body_radius != '0);
  end

  always_ff @(posedge clk) begin
    p1    <= p1_next;
    p1_gr <= surface_gravity * body_radius;
    p1_rr <= body_radius * body_radius;
    p1_dd <= distance[29:0] * distance[29:0];
  end

  // limit when R^2 > 10 * dist^2 (dist below 2^30 so the product stays exact)
  always_comb begin
    clamp_lim = {1'b0, p1_dd, 3'b000} + {3'b000, p1_dd, 1'b0};
    clamp     = p1.active && (surface_gravity != '0) && (p1.distance[DIST_W-1:30] == '0)
                && ({2'b00, p1_rr} > clamp_lim);
    sd_a_next       = p1;
    sd_a_next.clamp = clamp;
  end

  igf_div_chain u_div_a (
    .clk      (clk),
    .dividend ({{(DVD_W-62){1'b0}}, p1_gr}),
    .divisor  (p1.distance),
    .quotient (quot_a)
  );

  always_ff @(posedge clk) begin
    sd_a[0] <= sd_a_next;
    for (int k = 1; k < DIV_N; k++) begin
      sd_a[k] <= sd_a[k-1];
    end
  end

  // t * R, kept modulo 2^64
  always_comb begin
    tr_full = {26'd0, pa_lo} + {pa_hi, 26'd0};
  end

  always_ff @(posedge clk) begin
    p2    <= sd_a[DIV_N-1];
    pa_lo <= quot_a[25:0] * body_radius;
    pa_hi <= quot_a[51:26] * body_radius;
    p3    <= p2;
    tr    <= tr_full[63:0];
  end

  igf_div_chain u_div_b (
    .clk      (clk),
    .dividend ({{(DVD_W-64){1'b0}}, tr}),
    .divisor  (p3.distance),
    .quotient (quot_b)
  );

  always_ff @(posedge clk) begin
    sd_b[0] <= p3;
    for (int k = 1; k < DIV_N; k++) begin
      sd_b[k] <= sd_b[k-1];
    end
  end

  assign g_ten = {18'd0, surface_gravity, 3'b000} + {20'd0, surface_gravity, 1'b0};

  always_ff @(posedge clk) begin
    p4 <= sd_b[DIV_N-1];
    if (!sd_b[DIV_N-1].active) begin
      strength <= '0;
    end else if (sd_b[DIV_N-1].clamp) begin
      strength <= g_ten;
    end else begin
      strength <= quot_b;
    end
    p5 <= p4;
    for (int i = 0; i < 3; i++) begin
      pb_lo[i] <= p4.mag[i] * strength[25:0];
      pb_hi[i] <= p4.mag[i] * strength[51:26];
      prod[i]  <= {26'd0, pb_lo[i]} + {pb_hi[i], 26'd0};
    end
    p6 <= p5;
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    igf_div_chain u_div_c (
      .clk      (clk),
      .dividend ({{(DVD_W-84){1'b0}}, prod[i]}),
      .divisor  (p6.distance),
      .quotient (quot_c[i])
    );
  end

  always_ff @(posedge clk) begin
    sd_c[0] <= p6;
    for (int k = 1; k < DIV_N; k++) begin
      sd_c[k] <= sd_c[k-1];
    end
  end

  // sign, saturate, add velocity
  always_comb begin
    logic [QUO_W-1:0] q;
    logic [32:0]      s;
    for (int i = 0; i < 3; i++) begin
      q = quot_c[i];
      if (!sd_c[DIV_N-1].active) begin
        grav[i] = '0;
      end else if (!sd_c[DIV_N-1].neg[i]) begin
        grav[i] = (|q[QUO_W-1:31]) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
        grav[i] = ((|q[QUO_W-1:32]) || (q[31] && (|q[30:0]))) ? 32'h8000_0000
                                                             : 32'(-q[31:0]);
      end
      s = {sd_c[DIV_N-1].vel[i][31], sd_c[DIV_N-1].vel[i]} + {grav[i][31], grav[i]};
      if (s[32] != s[31]) begin
        new_vel[i] = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        new_vel[i] = s[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.grav_x    <= grav[0];
    result.grav_y    <= grav[1];
    result.grav_z    <= grav[2];
    result.new_vel_x <= new_vel[0];
    result.new_vel_y <= new_vel[1];
    result.new_vel_z <= new_vel[2];
    result.too_close <= sd_c[DIV_N-1].near;
    result.clamped   <= sd_c[DIV_N-1].clamp;
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.too_close && result.clamped))
    else $error("too_close and clamped both set");

  a_close_no_grav: assert property (@(posedge clk) disable iff (rst)
    (done && result.too_close) |->
      (result.grav_x == 0 && result.grav_y == 0 && result.grav_z == 0))
    else $error("gravity nonzero on a too-close item");

  a_done_tracks_accept: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

// File: dv/inverse_square_gravity_field_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_square_gravity_field_tb
// Drives query items through the gravity field pipeline under several
// attractor settings and checks each result against an in-bench predictor.
// ----------------------------------------------------------------------------
module inverse_square_gravity_field_tb;
  import igf_pkg::*;

  localparam int NUM_RANDOM = 1700;
  localparam int WDOG_LIMIT = 20000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  query_t  query = '0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic    done;
  result_t result;

  inverse_square_gravity_field u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  // attractor shadow
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0] radius, surf_g;

  result_t field_q[$];
  int      mismatches = 0;
  int      wdog = 0;
  int      idle_pct = 0;

  typedef struct {
    query_t q;
    bit     has_exp;
    result_t exp_r;
  } vec_t;

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [33:0] isqrt(logic [67:0] v);
    logic [35:0] rem;
    logic [33:0] root;
    logic [35:0] trial;
    rem = '0; root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = {rem[33:0], v[2*i+1 -: 2]};
      trial = {root, 2'b01};
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic result_t predict_field(query_t q);
    result_t r;
    logic signed [32:0] dir[3];
    logic signed [31:0] vel[3];
    logic [32:0] m;
    logic [67:0] sumsq;
    logic [33:0] distance;
    logic [127:0] strength, t, tr, p, quo, r128, g128;
    logic signed [65:0] gs[3];
    bit active;
    r = '0;
    dir[0] = 33'(ctr_x) - 33'(q.point_x);
    dir[1] = 33'(ctr_y) - 33'(q.point_y);
    dir[2] = 33'(ctr_z) - 33'(q.point_z);
    vel[0] = q.vel_x; vel[1] = q.vel_y; vel[2] = q.vel_z;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      m = dir[i] < 0 ? 33'(-dir[i]) : 33'(dir[i]);
      sumsq += 68'(m) * 68'(m);
      gs[i] = '0;
    end
    distance = isqrt(sumsq);
    active = 0;
    strength = '0;
    r128 = 128'(radius);
    g128 = 128'(surf_g);
    if (distance < NEAR_RAW) r.too_close = 1'b1;
    else if (radius != 0) begin
      active = 1;
      if (surf_g != 0 && distance < (34'd1 << 30) &&
          r128 * r128 > 128'd10 * 128'(distance) * 128'(distance)) begin
        r.clamped = 1'b1;
        strength = 128'd10 * g128;
      end else begin
        t = (g128 * r128) / 128'(distance);
        // t * R wraps at 64 bits
        tr = t * r128;
        strength = 128'(tr[63:0]) / 128'(distance);
      end
    end
    if (active)
      for (int i = 0; i < 3; i++) begin
        m = dir[i] < 0 ? 33'(-dir[i]) : 33'(dir[i]);
        p = 128'(m) * strength;
        quo = p / 128'(distance);
        if (quo > (128'd1 << 32)) quo = 128'd1 << 32;
        gs[i] = dir[i] < 0 ? -66'sd0 - $signed(66'(quo)) : $signed(66'(quo));
        gs[i] = sat32(gs[i]);
      end
    r.grav_x = gs[0][31:0]; r.grav_y = gs[1][31:0]; r.grav_z = gs[2][31:0];
    r.new_vel_x = sat32(66'(vel[0]) + gs[0]);
    r.new_vel_y = sat32(66'(vel[1]) + gs[1]);
    r.new_vel_z = sat32(66'(vel[2]) + gs[2]);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (field_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        result_t e;
        e = field_q.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h got %h", e, result);
        end
      end
    end
  end

  // watchdog on accepted handshakes
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("inverse_square_gravity_field verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_X:  ctr_x = val;
      REG_CENTER_Y:  ctr_y = val;
      REG_CENTER_Z:  ctr_z = val;
      REG_RADIUS:    radius = val[30:0];
      REG_SURF_GRAV: surf_g = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipe();
    while (field_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  // sends one item; caller is at a falling edge
  task automatic send_query(query_t q, bit has_exp, result_t exp_r);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    query <= q;
    do @(posedge clk); while (busy);
    if (has_exp && predict_field(q) !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("predictor disagrees with table row");
    end
    field_q.push_back(predict_field(q));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(20000)) - 10000);
      2: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.point_x = ctr_x + rand_coord();
    q.point_y = ctr_y + rand_coord();
    q.point_z = ctr_z + rand_coord();
    if ($urandom_range(9) == 0) begin
      q.point_x = ctr_x + 32'($signed($urandom_range(6000)) - 3000);
      q.point_y = ctr_y;
      q.point_z = ctr_z + 32'($signed($urandom_range(6000)) - 3000);
    end
    q.vel_x = $urandom_range(3) == 0 ? $urandom : rand_coord();
    q.vel_y = $urandom;
    q.vel_z = rand_coord();
    return q;
  endfunction

  vec_t dir_tab[$];

  task automatic add_row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                         bit has_exp, result_t e);
    vec_t v;
    v.q = '{px, py, pz, vx, vy, vz};
    v.has_exp = has_exp;
    v.exp_r = e;
    dir_tab.push_back(v);
  endtask

  initial begin
    result_t none;
    result_t near_r;
    none = '0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    radius = RADIUS_RESET; surf_g = GRAV_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, default attractor
    near_r = '0; near_r.too_close = 1'b1;
    near_r.new_vel_x = 32'h12345678; near_r.new_vel_y = 32'h80000000;
    near_r.new_vel_z = 32'h7fffffff;
    add_row(0, 0, 0, 32'h12345678, 32'h80000000, 32'h7fffffff, 1, near_r);
    near_r.new_vel_x = 0; near_r.new_vel_y = 0; near_r.new_vel_z = 0;
    add_row(6553, 0, 0, 0, 0, 0, 1, near_r);
    // surface point on x axis: strength = g, grav_x = -g... direction toward center
    none.grav_x = -32'sd642908; none.new_vel_x = -32'sd642908;
    add_row(32'h10000, 0, 0, 0, 0, 0, 1, none);
    add_row(6554, 0, 0, 0, 0, 0, 0, none);
    add_row(0, 32'h4000, 0, 32'h7fffffff, 32'h80000000, 0, 0, none);
    add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 0, none);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 0, none);
    add_row(32'h80000000, 32'h7fffffff, 0, 32'hffffffff, 1, 32'h55555555, 0, none);
    add_row(32'hfffe0000, 32'h30000, 32'hffff8000, 32'haaaaaaaa, 0, 0, 0, none);
    add_row(0, 0, 32'h200000, 32'h7ffffff0, 32'h80000010, 0, 0, none);
    foreach (dir_tab[i]) send_query(dir_tab[i].q, dir_tab[i].has_exp, dir_tab[i].exp_r);
    start <= 1'b0;
    drain_pipe();

    // zero radius and zero gravity cases, plus extreme register values
    write_reg(REG_RADIUS, 32'h0);
    send_query('{32'h10000, 0, 0, 5, 6, 7}, 1, '{0, 0, 0, 5, 6, 7, 0, 0});
    start <= 1'b0;
    drain_pipe();
    write_reg(REG_RADIUS, 32'hffffffff);
    write_reg(REG_SURF_GRAV, 32'h0);
    send_query('{32'h10000, 0, 0, 5, 6, 7}, 1, '{0, 0, 0, 5, 6, 7, 0, 0});
    start <= 1'b0;
    drain_pipe();
    write_reg(REG_SURF_GRAV, 32'h7fffffff);
    for (int i = 0; i < 6; i++) send_query(rand_query(), 0, '0);
    start <= 1'b0;
    drain_pipe();
    write_reg(REG_CENTER_X, 32'h7fffffff);
    write_reg(REG_CENTER_Y, 32'h80000000);
    write_reg(REG_CENTER_Z, 32'h7fffffff);
    for (int i = 0; i < 6; i++) send_query(rand_query(), 0, '0);
    start <= 1'b0;
    drain_pipe();

    // random phases with varied attractor settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CENTER_X, ph < 2 ? 32'h0 : $urandom);
      write_reg(REG_CENTER_Y, rand_coord());
      write_reg(REG_CENTER_Z, rand_coord());
      case (ph % 3)
        0: write_reg(REG_RADIUS, $urandom_range(1 << 20));
        1: write_reg(REG_RADIUS, $urandom);
        default: write_reg(REG_RADIUS, $urandom_range(40 << 16));
      endcase
      write_reg(REG_SURF_GRAV, ph == 5 ? $urandom : $urandom_range(50 << 16));
      idle_pct = ph < 2 ? 14 : (ph < 4 ? 53 : 0);
      for (int i = 0; i < NUM_RANDOM / 6; i++) begin
        send_query(rand_query(), 0, '0);
        // one full hold-off until the pipe is empty
        if (ph == 1 && i == 100) begin
          start <= 1'b0;
          while (field_q.size() != 0) @(negedge clk);
        end
      end
      start <= 1'b0;
      drain_pipe();
    end

    if (mismatches == 0 && field_q.size() == 0)
      $display("inverse_square_gravity_field verification clean");
    else
      $display("inverse_square_gravity_field verification failed");
    $finish;
  end

endmodule
